[src/epp_pkg.sv]
// Shared constants, register codes and arithmetic helpers for the encoder PLL estimator.
package epp_pkg;

  localparam int CPR_BITS = 14;
  localparam int TBL_BITS = 7;
  localparam int TBL_N = 1 << TBL_BITS;
  localparam int SEG_BITS = CPR_BITS - TBL_BITS;
  localparam logic [CPR_BITS-1:0] HALF_TURN = 14'd8192;
  localparam int APB_ADDR_W = 5;

  // ceil(2^32 / 5): the low-pass divide is a multiply by this and a one-step fix.
  localparam logic signed [32:0] LP_RECIP = 33'sd858993460;
  localparam logic signed [34:0] LP_DIV = 35'sd5;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [2:0] {
    REG_POLE   = 3'd0,
    REG_CCW    = 3'd1,
    REG_OFFSET = 3'd2,
    REG_PERIOD = 3'd3,
    REG_PGAIN  = 3'd4,
    REG_IGAIN  = 3'd5,
    REG_ZTHR   = 3'd6
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Shortest-path wrap of a one-turn difference into (-CPR/2, CPR/2].
  function automatic logic signed [CPR_BITS:0] halfwrap(input logic [CPR_BITS-1:0] d);
    logic signed [CPR_BITS:0] r;
    if (d > HALF_TURN) r = signed'({1'b0, d}) - signed'({1'b1, {CPR_BITS{1'b0}}});
    else r = signed'({1'b0, d});
    return r;
  endfunction

endpackage

[src/epp_if.sv]
// Request channel interfaces for the estimator input and result streams.
interface epp_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic [7:0]        frame_byte0;
  logic [7:0]        frame_byte1;
  logic [7:0]        frame_byte2;
  logic [6:0]        table_index;
  logic signed [15:0] table_value;
  modport source(output valid, action, frame_byte0, frame_byte1, frame_byte2,
                 table_index, table_value, input ready);
  modport sink(input valid, action, frame_byte0, frame_byte1, frame_byte2,
               table_index, table_value, output ready);
endinterface

interface epp_out_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic [1:0]         field_status;
  logic [7:0]         error_count;
  logic [13:0]        count_in_turn;
  logic signed [31:0] multi_turn_count;
  logic signed [31:0] velocity_turns;
  logic [26:0]        electrical_angle;
  logic signed [31:0] electrical_velocity;
  modport source(output valid, frame_ok, field_status, error_count, count_in_turn,
                 multi_turn_count, velocity_turns, electrical_angle,
                 electrical_velocity, input ready);
  modport sink(input valid, frame_ok, field_status, error_count, count_in_turn,
               multi_turn_count, velocity_turns, electrical_angle,
               electrical_velocity, output ready);
endinterface

[src/epp_mul.sv]
// Shared signed multiplier with a registered product.
module epp_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[src/encoder_pll_position_estimator.sv]
// Top level: register port, offset table, and the sequencer around one shared multiplier.
// A sensor frame passes through the linearisation, count, PLL, low-pass and electrical
// states before its result is loaded; a table write goes from idle straight to the output
// state. The frame path is set by the chain of eight dependent products that all pass
// through the single registered multiplier, plus two table reads through the one read
// port of the offset memory. The input is not ready while a request is being worked on.
// A finished result sits in the output register, and the next request is taken meanwhile.
// The offset table reads as zero after reset through per-entry valid bits, so no clearing
// pass is needed. Registers sit at byte address 4*i and read back as written.
module encoder_pll_position_estimator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [epp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  epp_in_if.sink                         in_ch,
  epp_out_if.source                      out_ch
);
  import epp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LIN0, S_LIN1, S_LIN2, S_CNT, S_POS1, S_DPOS, S_INTEG,
    S_VEL, S_FRAC, S_LP, S_LPQ, S_LPC, S_EA, S_EV, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [4:0]  pole_num;
  logic        ccw;
  logic [13:0] angle_offset;
  logic [23:0] sample_period;
  logic [23:0] prop_gain;
  logic [23:0] integ_gain;
  logic [30:0] zero_thr;

  // estimator state
  logic [13:0]        raw_angle;
  logic [13:0]        prev_count;
  logic signed [31:0] turn_acc;
  logic [29:0]        pll_pos;
  logic signed [31:0] pll_vel;
  logic [16:0]        sub_frac;
  logic signed [31:0] filt_vel;
  logic [7:0]         reject_cnt;

  // per-request working values
  logic               tbl_item;
  logic               ok_q;
  logic [1:0]         status_q;
  logic signed [15:0] o1;
  logic [13:0]        count_q;
  logic signed [14:0] delta_q;
  logic signed [14:0] dpos_q;
  logic               snap_q;
  logic signed [32:0] diff_q;
  logic signed [32:0] q0_q;
  logic [26:0]        ea_q;
  logic signed [31:0] ev_q;

  // offset table
  logic signed [15:0] tbl_mem [TBL_N];
  logic [TBL_N-1:0]   tbl_vld;
  logic [TBL_BITS-1:0] rd_addr;
  logic signed [15:0] rd_raw;
  logic               rd_vld;
  logic signed [15:0] rd_data;
  logic               tbl_we;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic in_acc, out_acc, cfg_wr;
  logic [1:0]  in_status;
  logic [13:0] in_angle;

  epp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  assign in_status = in_ch.frame_byte2[7:6];
  assign in_angle = ccw ? 14'(-{in_ch.frame_byte0, in_ch.frame_byte1[7:2]})
                        : {in_ch.frame_byte0, in_ch.frame_byte1[7:2]};
  assign tbl_we = in_acc && in_ch.action;

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      pole_num <= '0; ccw <= 1'b0; angle_offset <= '0; sample_period <= '0;
      prop_gain <= '0; integ_gain <= '0; zero_thr <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_POLE:   pole_num <= pwdata[4:0];
        REG_CCW:    ccw <= pwdata[0];
        REG_OFFSET: angle_offset <= pwdata[13:0];
        REG_PERIOD: sample_period <= pwdata[23:0];
        REG_PGAIN:  prop_gain <= pwdata[23:0];
        REG_IGAIN:  integ_gain <= pwdata[23:0];
        REG_ZTHR:   zero_thr <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_POLE:   prdata = {27'd0, pole_num};
      REG_CCW:    prdata = {31'd0, ccw};
      REG_OFFSET: prdata = {18'd0, angle_offset};
      REG_PERIOD: prdata = {8'd0, sample_period};
      REG_PGAIN:  prdata = {8'd0, prop_gain};
      REG_IGAIN:  prdata = {8'd0, integ_gain};
      REG_ZTHR:   prdata = {1'b0, zero_thr};
      default:    prdata = '0;
    endcase
  end

  // offset table memory
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[in_ch.table_index] <= in_ch.table_value;
    rd_raw <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (tbl_we) tbl_vld[in_ch.table_index] <= 1'b1;
      rd_vld <= tbl_vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_raw : 16'sd0;

  // datapath helpers
  logic signed [16:0] lin_corr;
  logic signed [17:0] lin_tmp;
  logic [13:0]        count_w;
  logic signed [14:0] delta_w;
  logic [29:0]        pos_adv;
  logic signed [14:0] dpos_w;
  logic signed [33:0] vsum;
  logic signed [31:0] vsat;
  logic [31:0]        vabs;
  logic               snap_w;
  logic signed [49:0] frac_step;
  logic signed [50:0] frac_sum;
  logic [16:0]        frac_w;
  logic signed [32:0] diff_w;
  logic signed [34:0] q0x, five_q, lp_rem, lp_q, filt_sum;
  logic [29:0]        interp;

  assign lin_corr = mul_p[23:7];
  assign lin_tmp  = {{2{o1[15]}}, o1} + {lin_corr[16], lin_corr};
  assign count_w  = raw_angle - lin_tmp[13:0];
  assign delta_w  = halfwrap(count_w - prev_count);
  assign pos_adv  = pll_pos + mul_p[45:16];
  assign dpos_w   = halfwrap(count_q - pll_pos[29:16]);

  assign vsum   = {{2{pll_vel[31]}}, pll_vel} + mul_p[41:8];
  assign vsat   = sat32({{32{vsum[33]}}, vsum});
  assign vabs   = vsat[31] ? 32'(-vsat) : 32'(vsat);
  assign snap_w = vabs < {1'b0, zero_thr};

  assign frac_step = mul_p[65:16];
  assign frac_sum  = signed'({34'd0, sub_frac}) + {frac_step[49], frac_step};
  always_comb begin
    if (snap_q) frac_w = 17'd32768;
    else if (delta_q > 15'sd0) frac_w = 17'd0;
    else if (delta_q < 15'sd0) frac_w = 17'd65536;
    else if (frac_sum > 51'sd65536) frac_w = 17'd65536;
    else if (frac_sum < 51'sd0) frac_w = 17'd0;
    else frac_w = frac_sum[16:0];
  end

  assign diff_w = {{7{pll_vel[31]}}, pll_vel[31:6]} - {filt_vel[31], filt_vel};

  // The reciprocal estimate is off by at most one; the remainder check fixes it.
  assign q0x    = {{2{q0_q[32]}}, q0_q};
  assign five_q = (q0x <<< 2) + q0x;
  assign lp_rem = {{2{diff_q[32]}}, diff_q} - five_q;
  always_comb begin
    if (lp_rem < 35'sd0) lp_q = q0x - 35'sd1;
    else if (lp_rem >= LP_DIV) lp_q = q0x + 35'sd1;
    else lp_q = q0x;
  end
  assign filt_sum = {{3{filt_vel[31]}}, filt_vel} + lp_q;

  assign interp = {14'(count_q - angle_offset), 16'd0} + {13'd0, sub_frac};

  // multiplier operands and table address by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    rd_addr = raw_angle[CPR_BITS-1:SEG_BITS];
    case (state)
      S_LIN1: rd_addr = TBL_BITS'(raw_angle[CPR_BITS-1:SEG_BITS] + 1'b1);
      S_LIN2: begin
        mul_a = {{17{rd_data[15]}}, rd_data} - {{17{o1[15]}}, o1};
        mul_b = {{(33-SEG_BITS){1'b0}}, raw_angle[SEG_BITS-1:0]};
      end
      S_CNT: begin
        mul_a = {9'd0, sample_period};
        mul_b = {pll_vel[31], pll_vel};
      end
      S_DPOS: begin
        mul_a = {9'd0, prop_gain};
        mul_b = {{18{dpos_w[14]}}, dpos_w};
      end
      S_INTEG: begin
        mul_a = {9'd0, integ_gain};
        mul_b = {{18{dpos_q[14]}}, dpos_q};
      end
      S_FRAC: begin
        mul_a = {9'd0, sample_period};
        mul_b = {pll_vel[31], pll_vel};
      end
      S_LP: begin
        mul_a = diff_w;
        mul_b = LP_RECIP;
      end
      S_LPC: begin
        mul_a = {3'd0, interp};
        mul_b = {28'd0, pole_num};
      end
      S_EA: begin
        mul_a = {filt_vel[31], filt_vel};
        mul_b = {28'd0, pole_num};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      raw_angle <= '0; prev_count <= '0; turn_acc <= '0; pll_pos <= '0;
      pll_vel <= '0; sub_frac <= '0; filt_vel <= '0; reject_cnt <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_acc && state != S_FIN) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            tbl_item <= in_ch.action;
            status_q <= in_status;
            ok_q <= (in_status == 2'd0);
            if (in_ch.action) begin
              state <= S_FIN;
            end else begin
              if (in_status == 2'd0) begin
                raw_angle <= in_angle;
              end else if (reject_cnt != 8'hFF) begin
                reject_cnt <= reject_cnt + 8'd1;
              end
              state <= S_LIN0;
            end
          end
        end
        S_LIN0: state <= S_LIN1;
        S_LIN1: begin
          o1 <= rd_data;
          state <= S_LIN2;
        end
        S_LIN2: state <= S_CNT;
        S_CNT: begin
          count_q <= count_w;
          delta_q <= delta_w;
          prev_count <= count_w;
          turn_acc <= turn_acc + {{17{delta_w[14]}}, delta_w};
          state <= S_POS1;
        end
        S_POS1: begin
          pll_pos <= pos_adv;
          state <= S_DPOS;
        end
        S_DPOS: begin
          dpos_q <= dpos_w;
          state <= S_INTEG;
        end
        S_INTEG: begin
          pll_pos <= pll_pos + mul_p[29:0];
          state <= S_VEL;
        end
        S_VEL: begin
          pll_vel <= snap_w ? 32'sd0 : vsat;
          snap_q <= snap_w;
          state <= S_FRAC;
        end
        S_FRAC: state <= S_LP;
        S_LP: begin
          sub_frac <= frac_w;
          diff_q <= diff_w;
          state <= S_LPQ;
        end
        S_LPQ: begin
          q0_q <= mul_p[64:32];
          state <= S_LPC;
        end
        S_LPC: begin
          filt_vel <= sat32({{31{filt_sum[34]}}, filt_sum});
          state <= S_EA;
        end
        S_EA: begin
          ea_q <= mul_p[34:8];
          state <= S_EV;
        end
        S_EV: begin
          ev_q <= sat32(mul_p);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.error_count <= reject_cnt;
            if (tbl_item) begin
              out_ch.frame_ok <= 1'b0;
              out_ch.field_status <= '0;
              out_ch.count_in_turn <= '0;
              out_ch.multi_turn_count <= '0;
              out_ch.velocity_turns <= '0;
              out_ch.electrical_angle <= '0;
              out_ch.electrical_velocity <= '0;
            end else begin
              out_ch.frame_ok <= ok_q;
              out_ch.field_status <= status_q;
              out_ch.count_in_turn <= count_q;
              out_ch.multi_turn_count <= turn_acc;
              out_ch.velocity_turns <= filt_vel;
              out_ch.electrical_angle <= ea_q;
              out_ch.electrical_velocity <= ev_q;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/epp_chk.sv]
// Port-level checks for the estimator, attached to the top level by bind.
module epp_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       frame_ok,
  input logic [1:0] field_status,
  input logic [7:0] error_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(error_count) && $stable(frame_ok))
    else $error("stalled result changed");

  // Only one request is worked on at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> field_status == 2'd0)
    else $error("frame taken with nonzero field status");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");
endmodule

bind encoder_pll_position_estimator epp_chk u_epp_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .frame_ok(out_ch.frame_ok),
  .field_status(out_ch.field_status),
  .error_count(out_ch.error_count)
);
